@@ rtl/core/prf_pkg.sv @@
// shared types and constants of the page replacement block
// no dependencies; used by prf_cell and page_replacement_fifo_lru
package prf_pkg;

  localparam int FRAMES_LIMIT = 64;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = IDX_W + 1;
  localparam int PAGE_W       = 8;
  localparam int FCNT_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;
  localparam int TOTAL_W      = 32;
  localparam int SLOT_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd1;

  localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = 4'd3;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // search word handed from cell to cell
  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  hit_rank;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  best_rank;
    logic [IDX_W-1:0]  best_idx;
    logic [PAGE_W-1:0] best_page;
    logic              tgt_valid;
    logic [IDX_W-1:0]  tgt_rank;
    logic [PAGE_W-1:0] tgt_page;
    logic [CNT_W-1:0]  vcnt;
  } carry_t;

  // update broadcast to every cell at the end of a sweep
  typedef struct packed {
    logic              en;
    logic              clear;
    logic [IDX_W-1:0]  slot;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  limit;
  } upd_t;

endpackage

@@ rtl/core/prf_cell.sv @@
// one frame cell: page, valid bit and recency rank, plus one stage of the search chain
// depends on prf_pkg
module prf_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  prf_pkg::carry_t           carry_i,
  input  logic [prf_pkg::PAGE_W-1:0] page_i,
  input  logic [prf_pkg::CNT_W-1:0] n_i,
  input  logic [prf_pkg::IDX_W-1:0] tgt_slot_i,
  input  prf_pkg::upd_t             upd_i,
  output prf_pkg::carry_t           carry_o
);

  localparam logic [prf_pkg::IDX_W-1:0] IdxC = prf_pkg::IDX_W'(IDX);
  localparam logic [prf_pkg::CNT_W-1:0] IdxN = prf_pkg::CNT_W'(IDX);

  logic                       valid_q;
  logic [prf_pkg::IDX_W-1:0]  rank_q;
  logic [prf_pkg::PAGE_W-1:0] page_q;
  logic                       tok_q;
  prf_pkg::carry_t            carry_d;
  prf_pkg::carry_t            carry_q;
  logic                       in_range;

  assign in_range = IdxN < n_i;

  always_comb begin
    carry_d = carry_i;
    if (in_range && valid_q && (page_q == page_i) && !carry_i.hit) begin
      carry_d.hit      = 1'b1;
      carry_d.hit_idx  = IdxC;
      carry_d.hit_rank = rank_q;
    end
    if (in_range && !valid_q && !carry_i.free) begin
      carry_d.free     = 1'b1;
      carry_d.free_idx = IdxC;
    end
    if (in_range && ((IdxC == '0) || (rank_q > carry_i.best_rank))) begin
      carry_d.best_rank = rank_q;
      carry_d.best_idx  = IdxC;
      carry_d.best_page = page_q;
    end
    if (IdxC == tgt_slot_i) begin
      carry_d.tgt_valid = valid_q;
      carry_d.tgt_rank  = rank_q;
      carry_d.tgt_page  = page_q;
    end
    carry_d.vcnt = carry_i.vcnt + prf_pkg::CNT_W'(valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= carry_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (carry_i.tok) begin
      carry_q <= carry_d;
    end
  end

  always_comb begin
    carry_o     = carry_q;
    carry_o.tok = tok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.clear) begin
        valid_q <= 1'b0;
        rank_q  <= '0;
      end else if (upd_i.slot == IdxC) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q && ({1'b0, rank_q} < upd_i.limit)) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && (upd_i.slot == IdxC)) begin
      page_q <= upd_i.page;
    end
  end

endmodule

@@ rtl/core/page_replacement_fifo_lru.sv @@
// sweep: an accepted start launches a search token that passes the cell registers in order, then done_o is registered
// a new word is accepted only in ST_IDLE, once the search token of the last word has left the cell chain
// the receiver cannot stall: each result shows on done_o for one cycle
// reset: frames invalid, ranks, fill pointer and fault count zero, frame_count 3, policy FIFO
// holds the controller and the row of prf_cell frames; depends on prf_pkg and prf_cell
module page_replacement_fifo_lru #(
  parameter int MAX_FRAMES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [prf_pkg::PAGE_W-1:0]     page_i,
  input  logic                           last_ref_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic                           fault_o,
  output logic [prf_pkg::SLOT_W-1:0]     slot_o,
  output logic                           evicted_valid_o,
  output logic [prf_pkg::PAGE_W-1:0]     evicted_page_o,
  output logic [prf_pkg::TOTAL_W-1:0]    fault_total_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  state_e                       state_q;
  logic                         launch_q;
  logic [prf_pkg::FCNT_W-1:0]   frame_count_q;
  logic                         policy_q;
  logic [prf_pkg::PAGE_W-1:0]   item_page_q;
  logic                         item_last_q;
  logic [prf_pkg::IDX_W-1:0]    tgt_slot_q;
  logic [prf_pkg::CNT_W-1:0]    fp_q;
  logic [prf_pkg::TOTAL_W-1:0]  cnt_q;
  logic                         done_q;
  logic                         fault_q;
  logic [prf_pkg::SLOT_W-1:0]   slot_q;
  logic                         ev_valid_q;
  logic [prf_pkg::PAGE_W-1:0]   ev_page_q;
  logic [prf_pkg::TOTAL_W-1:0]  total_q;

  logic [prf_pkg::CNT_W-1:0]    n_w;
  logic [prf_pkg::CNT_W-1:0]    fp_eff;
  logic                         accept;
  prf_pkg::carry_t              chain [MAX_FRAMES+1];
  prf_pkg::carry_t              fin;
  prf_pkg::upd_t                upd;
  logic [prf_pkg::IDX_W-1:0]    slot_w;
  logic [prf_pkg::CNT_W-1:0]    limit_w;
  logic                         ev_w;
  logic [prf_pkg::PAGE_W-1:0]   evp_w;
  logic [prf_pkg::TOTAL_W-1:0]  cnt_d;
  logic [MAX_FRAMES-1:0]        tok_vec;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q == ST_SWEEP);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (frame_count_q == '0) begin
      n_w = prf_pkg::CNT_W'(1);
    end else if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
      n_w = prf_pkg::CNT_W'(MAX_FRAMES);
    end else begin
      n_w = prf_pkg::CNT_W'(frame_count_q);
    end
  end

  assign fp_eff = (fp_q >= n_w) ? '0 : fp_q;

  always_comb begin
    chain[0]     = '0;
    chain[0].tok = launch_q;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    prf_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .carry_i   (chain[g]),
      .page_i    (item_page_q),
      .n_i       (n_w),
      .tgt_slot_i(tgt_slot_q),
      .upd_i     (upd),
      .carry_o   (chain[g+1])
    );
    assign tok_vec[g] = chain[g+1].tok;
  end

  assign fin = chain[MAX_FRAMES];

  always_comb begin
    slot_w  = tgt_slot_q;
    limit_w = fin.vcnt;
    ev_w    = 1'b0;
    evp_w   = '0;
    if (fin.hit) begin
      slot_w  = fin.hit_idx;
      limit_w = {1'b0, fin.hit_rank};
    end else if (policy_q == prf_pkg::POL_LRU) begin
      if (fin.free) begin
        slot_w = fin.free_idx;
      end else begin
        slot_w  = fin.best_idx;
        limit_w = {1'b0, fin.best_rank};
        ev_w    = 1'b1;
        evp_w   = fin.best_page;
      end
    end else if (fin.tgt_valid) begin
      limit_w = {1'b0, fin.tgt_rank};
      ev_w    = 1'b1;
      evp_w   = fin.tgt_page;
    end
  end

  assign cnt_d = (!fin.hit && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    upd.en    = fin.tok;
    upd.clear = item_last_q;
    upd.slot  = slot_w;
    upd.page  = item_page_q;
    upd.limit = limit_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      launch_q      <= 1'b0;
      frame_count_q <= prf_pkg::FRAME_COUNT_RST;
      policy_q      <= prf_pkg::POL_FIFO;
      item_page_q   <= '0;
      item_last_q   <= 1'b0;
      tgt_slot_q    <= '0;
      fp_q          <= '0;
      cnt_q         <= '0;
      done_q        <= 1'b0;
      fault_q       <= 1'b0;
      slot_q        <= '0;
      ev_valid_q    <= 1'b0;
      ev_page_q     <= '0;
      total_q       <= '0;
    end else begin
      launch_q <= accept;
      done_q   <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          prf_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data_i;
          prf_pkg::CFG_POLICY:      policy_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q     <= ST_SWEEP;
            item_page_q <= page_i;
            item_last_q <= last_ref_i;
            tgt_slot_q  <= prf_pkg::IDX_W'(fp_eff);
          end
        end
        ST_SWEEP: begin
          if (fin.tok) begin
            state_q    <= ST_IDLE;
            done_q     <= 1'b1;
            fault_q    <= !fin.hit;
            slot_q     <= slot_w[prf_pkg::SLOT_W-1:0];
            ev_valid_q <= ev_w;
            ev_page_q  <= evp_w;
            total_q    <= cnt_d;
            if (item_last_q) begin
              fp_q  <= '0;
              cnt_q <= '0;
            end else begin
              cnt_q <= cnt_d;
              if (!fin.hit && (policy_q == prf_pkg::POL_FIFO)) begin
                fp_q <= prf_pkg::CNT_W'(tgt_slot_q) + 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign fault_o         = fault_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = total_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the cell chain");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while a sweep is still running");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted word did not start a sweep");

  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_valid_o) |-> fault_o)
    else $error("eviction reported without a fault");

endmodule
